[rtl/hne_pkg.sv]
`timescale 1ns / 1ps
// Package for the heightmap normal estimator: field widths, payload structs,
// pipeline stage types and register indexes. No dependencies.
package hne_pkg;

  localparam int unsigned FRAC_BITS  = 14;
  localparam int unsigned COORD_BITS = 16;

  localparam int unsigned HEIGHT_W = 8;
  localparam int unsigned DIFF_W   = HEIGHT_W + 1;
  localparam int unsigned SQ_W     = 2 * HEIGHT_W;
  localparam int unsigned N_W      = SQ_W + 2;
  localparam int unsigned Q_W      = FRAC_BITS + 1;
  localparam int unsigned ACC_W    = 2 * FRAC_BITS + 24;
  localparam int unsigned STEPS    = FRAC_BITS + 1;
  localparam int unsigned BIT_W    = $clog2(STEPS);
  localparam int unsigned LANES    = 3;
  localparam int unsigned ONE_Q    = 1 << FRAC_BITS;

  localparam int unsigned NX_W = 16;
  localparam int unsigned NY_W = 15;
  localparam int unsigned NZ_W = 16;

  localparam int unsigned LANE_X = 0;
  localparam int unsigned LANE_Y = 1;
  localparam int unsigned LANE_Z = 2;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

  localparam logic [COORD_BITS-1:0] MAP_SIZE_RESET = COORD_BITS'(256);

  typedef struct packed {
    logic [COORD_BITS-1:0] x_coord;
    logic [COORD_BITS-1:0] z_coord;
    logic [HEIGHT_W-1:0]   height_mid;
    logic [HEIGHT_W-1:0]   height_up;
    logic [HEIGHT_W-1:0]   height_down;
    logic [HEIGHT_W-1:0]   height_left;
    logic [HEIGHT_W-1:0]   height_right;
  } in_item_t;

  typedef struct packed {
    logic [NX_W-1:0] normal_x;
    logic [NY_W-1:0] normal_y;
    logic [NZ_W-1:0] normal_z;
    logic            on_border;
  } out_item_t;

  // rem = target - (2q-1)^2 * n, m = (2q-1) * n, both two's complement
  typedef struct packed {
    logic [ACC_W-1:0] rem;
    logic [ACC_W-1:0] m;
    logic [Q_W-1:0]   q;
  } lane_t;

  typedef struct packed {
    logic                   valid;
    logic                   border;
    logic                   sx;
    logic                   sz;
    logic [N_W-1:0]         n;
    lane_t [LANES-1:0]      lane;
  } stage_t;

endpackage

[rtl/hne_front.sv]
`timescale 1ns / 1ps
// Front stages: border test, height differences, squares and seed values
// for the per-bit ratio steps. Depends on hne_pkg.
module hne_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  hne_pkg::in_item_t                  item_i,
  input  logic [hne_pkg::COORD_BITS-1:0]     map_width_i,
  input  logic [hne_pkg::COORD_BITS-1:0]     map_height_i,
  output hne_pkg::stage_t                    stage_o
);

  typedef struct packed {
    logic                             border;
    logic signed [hne_pkg::DIFF_W-1:0] dx;
    logic signed [hne_pkg::DIFF_W-1:0] dz;
  } diff_t;

  typedef struct packed {
    logic                          border;
    logic                          sx;
    logic                          sz;
    logic [hne_pkg::SQ_W-1:0]      dx2;
    logic [hne_pkg::SQ_W-1:0]      dz2;
  } square_t;

  logic    a_valid_q, b_valid_q, c_valid_q;
  diff_t   a_d, a_q;
  square_t b_d, b_q;
  hne_pkg::stage_t c_d, c_q;

  logic [hne_pkg::COORD_BITS:0]       x_inc, z_inc;
  logic signed [2*hne_pkg::DIFF_W-1:0] sqx, sqz;
  logic [hne_pkg::N_W-1:0]            n_sum;
  logic [hne_pkg::ACC_W-1:0]          n_ext;
  logic [hne_pkg::ACC_W-1:0]          sq_ext [hne_pkg::LANES];

  always_comb begin
    x_inc = {1'b0, item_i.x_coord} + (hne_pkg::COORD_BITS+1)'(1);
    z_inc = {1'b0, item_i.z_coord} + (hne_pkg::COORD_BITS+1)'(1);
    a_d.border = !((item_i.x_coord != '0) && (item_i.z_coord != '0) &&
                   (x_inc < {1'b0, map_width_i}) && (z_inc < {1'b0, map_height_i}));
    a_d.dx = $signed({1'b0, item_i.height_left}) - $signed({1'b0, item_i.height_right});
    a_d.dz = $signed({1'b0, item_i.height_down}) - $signed({1'b0, item_i.height_up});
  end

  always_comb begin
    sqx = a_q.dx * a_q.dx;
    sqz = a_q.dz * a_q.dz;
    b_d.border = a_q.border;
    b_d.sx     = a_q.dx[hne_pkg::DIFF_W-1];
    b_d.sz     = a_q.dz[hne_pkg::DIFF_W-1];
    b_d.dx2    = sqx[hne_pkg::SQ_W-1:0];
    b_d.dz2    = sqz[hne_pkg::SQ_W-1:0];
  end

  always_comb begin
    n_sum = hne_pkg::N_W'(b_q.dx2) + hne_pkg::N_W'(b_q.dz2) + hne_pkg::N_W'(4);
    n_ext = hne_pkg::ACC_W'(n_sum);
    sq_ext[hne_pkg::LANE_X] = hne_pkg::ACC_W'(b_q.dx2);
    sq_ext[hne_pkg::LANE_Y] = hne_pkg::ACC_W'(4);
    sq_ext[hne_pkg::LANE_Z] = hne_pkg::ACC_W'(b_q.dz2);
    c_d        = '0;
    c_d.border = b_q.border;
    c_d.sx     = b_q.sx;
    c_d.sz     = b_q.sz;
    c_d.n      = n_sum;
    for (int i = 0; i < hne_pkg::LANES; i++) begin
      c_d.lane[i].rem = (sq_ext[i] << (2 * hne_pkg::FRAC_BITS + 2)) - n_ext;
      c_d.lane[i].m   = '0 - n_ext;
      c_d.lane[i].q   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
  end

  always_comb begin
    stage_o       = c_q;
    stage_o.valid = c_valid_q;
  end

endmodule

[rtl/hne_div_step.sv]
`timescale 1ns / 1ps
// One registered step of the rounded ratio search: decides one quotient bit
// for all three lanes, each with shifts, one add and one compare. Depends on hne_pkg.
module hne_div_step (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [hne_pkg::BIT_W-1:0]      bit_i,
  input  hne_pkg::stage_t                stage_i,
  output hne_pkg::stage_t                stage_o
);

  logic                        valid_q;
  hne_pkg::stage_t             data_d, data_q;
  logic signed [hne_pkg::ACC_W-1:0] n_ext;
  logic signed [hne_pkg::ACC_W-1:0] term [hne_pkg::LANES];
  logic                        take [hne_pkg::LANES];

  always_comb begin
    n_ext  = $signed(hne_pkg::ACC_W'(stage_i.n));
    data_d = stage_i;
    for (int i = 0; i < hne_pkg::LANES; i++) begin
      term[i] = ($signed(stage_i.lane[i].m) <<< (bit_i + 2)) +
                (n_ext <<< ({bit_i, 1'b0} + 2));
      take[i] = term[i] <= $signed(stage_i.lane[i].rem);
      if (take[i]) begin
        data_d.lane[i].rem = stage_i.lane[i].rem - term[i];
        data_d.lane[i].m   = stage_i.lane[i].m + (n_ext <<< (bit_i + 1));
        data_d.lane[i].q   = stage_i.lane[i].q | (hne_pkg::Q_W'(1) << bit_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    stage_o       = data_q;
    stage_o.valid = valid_q;
  end

endmodule

[rtl/heightmap_normal_estimator_top.sv]
`timescale 1ns / 1ps
// Top level of the heightmap normal estimator: configuration registers,
// front stages, ratio step chain and result register. Depends on hne_pkg.
//
// Usage:
//   Input: drive item_i and raise start; the stencil transfers at every edge
//   with start high. busy stays low, so one stencil can enter each cycle.
//   Output: result_o is shown for exactly one cycle with result_valid_o high
//   and transfers at the edge that ends that cycle.
//   Results leave in input order; there is no back pressure.
//   The pipeline is three front stages (difference, square, seed), one
//   step per quotient bit (15 steps) and the result register.
//   Throughput: one normal per clock.
//   Configuration: cfg_ready_o is always high; index 0 writes map_width,
//   index 1 map_height, any other index is dropped. Write only while idle.
//   Reset: clears all valid bits and sets both map sizes to 256.
module heightmap_normal_estimator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  hne_pkg::in_item_t                   item_i,
  output logic                                result_valid_o,
  output hne_pkg::out_item_t                  result_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hne_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [hne_pkg::COORD_BITS-1:0]      cfg_data_i
);

  logic [hne_pkg::COORD_BITS-1:0] map_width_q, map_height_q;
  hne_pkg::stage_t                stage_w [hne_pkg::STEPS+1];
  hne_pkg::stage_t                last;
  logic                           result_valid_q;
  hne_pkg::out_item_t             result_d, result_q;
  logic [hne_pkg::Q_W:0]          qx_ext, qz_ext;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= hne_pkg::MAP_SIZE_RESET;
      map_height_q <= hne_pkg::MAP_SIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        hne_pkg::REG_MAP_WIDTH:  map_width_q  <= cfg_data_i;
        hne_pkg::REG_MAP_HEIGHT: map_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hne_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (start && !busy),
    .item_i       (item_i),
    .map_width_i  (map_width_q),
    .map_height_i (map_height_q),
    .stage_o      (stage_w[0])
  );

  for (genvar gi = 0; gi < hne_pkg::STEPS; gi++) begin : g_step
    hne_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bit_i   (hne_pkg::BIT_W'(hne_pkg::FRAC_BITS - gi)),
      .stage_i (stage_w[gi]),
      .stage_o (stage_w[gi+1])
    );
  end

  assign last = stage_w[hne_pkg::STEPS];

  always_comb begin
    qx_ext = {1'b0, last.lane[hne_pkg::LANE_X].q};
    qz_ext = {1'b0, last.lane[hne_pkg::LANE_Z].q};
    if (last.sx) begin
      qx_ext = '0 - qx_ext;
    end
    if (last.sz) begin
      qz_ext = '0 - qz_ext;
    end
    if (last.border) begin
      result_d.normal_x  = '0;
      result_d.normal_y  = hne_pkg::NY_W'(hne_pkg::ONE_Q);
      result_d.normal_z  = '0;
      result_d.on_border = 1'b1;
    end else begin
      result_d.normal_x  = hne_pkg::NX_W'($signed(qx_ext));
      result_d.normal_y  = hne_pkg::NY_W'(last.lane[hne_pkg::LANE_Y].q);
      result_d.normal_z  = hne_pkg::NZ_W'($signed(qz_ext));
      result_d.on_border = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  a_border_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.on_border |->
      result_o.normal_x == '0 && result_o.normal_z == '0 &&
      result_o.normal_y == hne_pkg::NY_W'(hne_pkg::ONE_Q))
    else $error("border result is not the default normal");

  a_interior_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.on_border |->
      result_o.normal_y != '0 &&
      int'(result_o.normal_y) <= int'(hne_pkg::ONE_Q))
    else $error("interior normal y component out of range");

  a_unit_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      int'($signed(result_o.normal_x)) <= int'(hne_pkg::ONE_Q) &&
      int'($signed(result_o.normal_x)) >= -int'(hne_pkg::ONE_Q) &&
      int'($signed(result_o.normal_z)) <= int'(hne_pkg::ONE_Q) &&
      int'($signed(result_o.normal_z)) >= -int'(hne_pkg::ONE_Q))
    else $error("normal component exceeds unit length");

  a_valid_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last.valid |=> result_valid_o)
    else $error("finished item did not reach the result register");

endmodule

[bench/tb_heightmap_normal_estimator_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for heightmap_normal_estimator_top: predicts each unit
// normal with exact integer math and checks every result in order.
// Depends on hne_pkg and the top level RTL.
module tb_heightmap_normal_estimator_top;

  localparam int unsigned RESULT_LATENCY = 19;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam logic [hne_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [hne_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  hne_pkg::in_item_t              item_i;
  logic                           result_valid_o;
  hne_pkg::out_item_t             result_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [hne_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [hne_pkg::COORD_BITS-1:0] cfg_data_i;

  hne_pkg::out_item_t expected_normals[$];
  int unsigned map_width_q  = 256;
  int unsigned map_height_q = 256;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;
  int unsigned sent_count = 0;

  heightmap_normal_estimator_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("heightmap_normal_estimator_top verification failed");
      $finish;
    end
  end

  // largest q with (2q-1)^2 * n <= (2 * mag * 2^FRAC_BITS)^2
  function automatic int unsigned unit_ratio(int unsigned mag, int unsigned n);
    longint unsigned scaled, target, trial, odd;
    int unsigned q;
    q = 0;
    scaled = longint'(mag) << (hne_pkg::FRAC_BITS + 1);
    target = scaled * scaled;
    for (int b = hne_pkg::FRAC_BITS; b >= 0; b--) begin
      trial = q | (64'd1 << b);
      odd = 2 * trial - 1;
      if (odd * odd * n <= target) q = trial[31:0];
    end
    return q;
  endfunction

  function automatic hne_pkg::out_item_t predict_normal(hne_pkg::in_item_t it);
    hne_pkg::out_item_t res;
    int unsigned px, pz, n;
    int dx, dz, qx, qy, qz;
    px = 32'(it.x_coord);
    pz = 32'(it.z_coord);
    if (px > 0 && pz > 0 && px + 1 < map_width_q && pz + 1 < map_height_q) begin
      dx = int'(it.height_left) - int'(it.height_right);
      dz = int'(it.height_down) - int'(it.height_up);
      n = dx * dx + dz * dz + 4;
      qx = unit_ratio(dx < 0 ? -dx : dx, n);
      qz = unit_ratio(dz < 0 ? -dz : dz, n);
      qy = unit_ratio(2, n);
      if (dx < 0) qx = -qx;
      if (dz < 0) qz = -qz;
      res.normal_x  = qx[hne_pkg::NX_W-1:0];
      res.normal_y  = qy[hne_pkg::NY_W-1:0];
      res.normal_z  = qz[hne_pkg::NZ_W-1:0];
      res.on_border = 1'b0;
    end else begin
      res.normal_x  = '0;
      res.normal_y  = hne_pkg::NY_W'(hne_pkg::ONE_Q);
      res.normal_z  = '0;
      res.on_border = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    hne_pkg::out_item_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_normals.size() == 0) begin
        $error("result with no stencil outstanding: %p", result_o);
        mismatch_count++;
      end else begin
        want = expected_normals.pop_front();
        if (result_o.normal_x !== want.normal_x) begin
          $error("normal_x expected %0d got %0d", $signed(want.normal_x),
                 $signed(result_o.normal_x));
          mismatch_count++;
        end
        if (result_o.normal_y !== want.normal_y) begin
          $error("normal_y expected %0d got %0d", want.normal_y, result_o.normal_y);
          mismatch_count++;
        end
        if (result_o.normal_z !== want.normal_z) begin
          $error("normal_z expected %0d got %0d", $signed(want.normal_z),
                 $signed(result_o.normal_z));
          mismatch_count++;
        end
        if (result_o.on_border !== want.on_border) begin
          $error("on_border expected %0d got %0d", want.on_border, result_o.on_border);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_stencil(hne_pkg::in_item_t it);
    if ((sent_count % 50) >= 10) begin
      while ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    expected_normals = {expected_normals, predict_normal(it)};
    sent_count++;
  endtask

  task automatic send_fields(int unsigned x, int unsigned z, int unsigned mid,
                             int unsigned up, int unsigned down,
                             int unsigned left, int unsigned right);
    hne_pkg::in_item_t it;
    it.x_coord      = x[hne_pkg::COORD_BITS-1:0];
    it.z_coord      = z[hne_pkg::COORD_BITS-1:0];
    it.height_mid   = mid[hne_pkg::HEIGHT_W-1:0];
    it.height_up    = up[hne_pkg::HEIGHT_W-1:0];
    it.height_down  = down[hne_pkg::HEIGHT_W-1:0];
    it.height_left  = left[hne_pkg::HEIGHT_W-1:0];
    it.height_right = right[hne_pkg::HEIGHT_W-1:0];
    send_stencil(it);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk_i);
    repeat (RESULT_LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [hne_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[hne_pkg::COORD_BITS-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == hne_pkg::REG_MAP_WIDTH) map_width_q = value & 16'hFFFF;
    else if (idx == hne_pkg::REG_MAP_HEIGHT) map_height_q = value & 16'hFFFF;
  endtask

  task automatic set_map(int unsigned width, int unsigned height);
    drain();
    write_reg(hne_pkg::REG_MAP_WIDTH, width);
    write_reg(hne_pkg::REG_MAP_HEIGHT, height);
  endtask

  function automatic int unsigned pick_coord(int unsigned size);
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 7 && size >= 3) return $urandom_range(size - 2, 1);
    if (sel < 8) return ($urandom_range(1) == 0) ? 0 : ((size == 0) ? 0 : size - 1);
    return $urandom_range(16'hFFFF);
  endfunction

  function automatic hne_pkg::in_item_t random_stencil();
    hne_pkg::in_item_t it;
    int unsigned style, base;
    it = hne_pkg::in_item_t'({$urandom, $urandom, $urandom});
    it.x_coord = hne_pkg::COORD_BITS'(pick_coord(map_width_q));
    it.z_coord = hne_pkg::COORD_BITS'(pick_coord(map_height_q));
    style = $urandom_range(3);
    if (style == 1) begin
      base = $urandom_range(247, 4);
      it.height_up    = hne_pkg::HEIGHT_W'(base + $urandom_range(4) - 2);
      it.height_down  = hne_pkg::HEIGHT_W'(base + $urandom_range(4) - 2);
      it.height_left  = hne_pkg::HEIGHT_W'(base + $urandom_range(4) - 2);
      it.height_right = hne_pkg::HEIGHT_W'(base + $urandom_range(4) - 2);
    end else if (style == 2) begin
      it.height_up    = {hne_pkg::HEIGHT_W{$urandom_range(1) == 1}};
      it.height_down  = {hne_pkg::HEIGHT_W{$urandom_range(1) == 1}};
      it.height_left  = {hne_pkg::HEIGHT_W{$urandom_range(1) == 1}};
      it.height_right = {hne_pkg::HEIGHT_W{$urandom_range(1) == 1}};
    end
    return it;
  endfunction

  task automatic test_border_points;
    send_fields(0, 0, 0, 0, 0, 0, 0);
    send_fields(255, 255, 255, 255, 255, 255, 255);
    send_fields(0, 128, 17, 200, 3, 90, 11);
    send_fields(128, 0, 17, 200, 3, 90, 11);
    send_fields(255, 128, 17, 200, 3, 90, 11);
    send_fields(128, 255, 17, 200, 3, 90, 11);
    send_fields(65535, 65535, 0, 255, 0, 255, 0);
  endtask

  task automatic test_slopes;
    send_fields(254, 254, 255, 255, 255, 255, 255);
    send_fields(1, 1, 0, 0, 0, 255, 0);
    send_fields(1, 254, 0, 0, 0, 0, 255);
    send_fields(254, 1, 255, 0, 255, 7, 7);
    send_fields(100, 200, 0, 255, 0, 9, 9);
    send_fields(170, 85, 128, 255, 0, 255, 0);
    send_fields(85, 170, 127, 0, 1, 1, 0);
  endtask

  task automatic test_map_extremes;
    set_map(65535, 65535);
    send_fields(65533, 65533, 42, 10, 20, 30, 40);
    send_fields(65534, 1, 42, 10, 20, 30, 40);
    set_map(0, 0);
    send_fields(1, 1, 5, 0, 255, 255, 0);
    set_map(1, 1);
    send_fields(0, 0, 5, 0, 255, 255, 0);
    set_map(3, 2);
    send_fields(1, 0, 5, 1, 2, 3, 4);
    set_map(3, 3);
    send_fields(1, 1, 5, 1, 2, 3, 4);
    drain();
    write_reg(REG_SPARE_2, 0);
    write_reg(REG_SPARE_3, 16'hFFFF);
    send_fields(1, 1, 99, 200, 100, 50, 250);
    send_fields(2, 1, 99, 200, 100, 50, 250);
  endtask

  task automatic test_random_phase(int unsigned pct, int unsigned width,
                                   int unsigned height, int unsigned count);
    set_map(width, height);
    idle_pct = pct;
    repeat (count) send_stencil(random_stencil());
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    item_i      <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_border_points();
    test_slopes();
    test_map_extremes();
    test_random_phase(0, 65535, 65535, 190);
    test_random_phase(53, 3, 200, 190);
    test_random_phase(0, $urandom_range(300, 4), $urandom_range(300, 4), 190);
    test_random_phase(31, $urandom_range(65535, 1), $urandom_range(65535, 1), 190);
    drain();

    if (mismatch_count == 0) begin
      $display("heightmap_normal_estimator_top verification clean");
    end else begin
      $display("heightmap_normal_estimator_top verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/hne_pkg.sv
rtl/hne_front.sv
rtl/hne_div_step.sv
rtl/heightmap_normal_estimator_top.sv
bench/tb_heightmap_normal_estimator_top.sv
